// ===== design/dccs_pkg.sv =====
package dccs_pkg;

  // Default sizing
  localparam int StackDepthDefault = 2;
  localparam int SliceQuotaDefault = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_TRANSFER_MODE     = 3'd0;
  localparam logic [2:0] REG_START_MEM_ADDRESS = 3'd1;
  localparam logic [2:0] REG_START_QWORD_COUNT = 3'd2;
  localparam logic [2:0] REG_START_TAG_ADDRESS = 3'd3;
  localparam logic [2:0] REG_TAG_IRQ_ENABLE    = 3'd4;
  localparam logic [2:0] REG_TRANSFER_RUN      = 3'd5;
  localparam logic [2:0] REG_SKIP_RUN          = 3'd6;
  localparam logic [2:0] REG_SLICE_MODE        = 3'd7;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 32;

  // Transfer modes
  localparam logic [1:0] MODE_NORMAL     = 2'd0;
  localparam logic [1:0] MODE_CHAIN      = 2'd1;
  localparam logic [1:0] MODE_INTERLEAVE = 2'd2;

  // Commands
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_RESUME = 2'd2;

  // Bus actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;
  localparam logic [1:0] ACT_SKIP  = 2'd3;

  // Channel status
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_FINISHED = 3'd1;
  localparam logic [2:0] ST_PAUSE    = 3'd2;
  localparam logic [2:0] ST_ZERO_ERR = 3'd3;
  localparam logic [2:0] ST_STOPPED  = 3'd4;

  // Tag IDs
  localparam logic [2:0] TAG_REFE = 3'd0;
  localparam logic [2:0] TAG_CNT  = 3'd1;
  localparam logic [2:0] TAG_NEXT = 3'd2;
  localparam logic [2:0] TAG_REF  = 3'd3;
  localparam logic [2:0] TAG_REFS = 3'd4;
  localparam logic [2:0] TAG_CALL = 3'd5;
  localparam logic [2:0] TAG_RET  = 3'd6;
  localparam logic [2:0] TAG_END  = 3'd7;

  localparam logic [30:0] QwordBytes = 31'h10;

  typedef struct packed {
    logic [1:0]  transfer_mode;
    logic [31:0] start_mem_address;
    logic [15:0] start_qword_count;
    logic [31:0] start_tag_address;
    logic        tag_irq_enable;
    logic [7:0]  transfer_run;
    logic [7:0]  skip_run;
    logic        slice_mode;
  } dccs_cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] bus_address;
    logic [2:0]  status;
    logic [2:0]  fetched_id;
  } dccs_result_t;

  // Step an address within bits 30:0, scratchpad bit held
  function automatic logic [31:0] adv(input logic [31:0] a, input logic [30:0] d);
    logic [30:0] low;
    low = a[30:0] + d;
    return {a[31], low};
  endfunction

endpackage

// ===== design/dccs_if.sv =====
interface dccs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] tag_word;
  modport source (output valid, output command, output tag_word, input ready);
  modport sink (input valid, input command, input tag_word, output ready);
endinterface

interface dccs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] bus_address;
  logic [2:0]  status;
  logic [2:0]  fetched_id;
  modport source (output valid, output action, output bus_address, output status,
                  output fetched_id, input ready);
  modport sink (input valid, input action, input bus_address, input status,
                input fetched_id, output ready);
endinterface

interface dccs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/dma_channel_chain_sequencer_core.sv =====
// Channel  Dir  Word contents
// req      in   command, tag_word
// rsp      out  action, bus_address, status, fetched_id
// cfg      in   index (register number), data
//
// One word in, one word out, one word per cycle unless rsp stalls. A result
// is offered on rsp once its req word has passed the input register, then
// the channel step into the result register; channel state steps with it.
// rst (synchronous) clears config and channel state; the return stack is not
// cleared. A stalled rsp holds the result and the input register; req.ready
// drops only when both are full. cfg is always ready.
module dma_channel_chain_sequencer_core #(
  parameter int STACK_DEPTH = dccs_pkg::StackDepthDefault,
  parameter int SLICE_QUOTA = dccs_pkg::SliceQuotaDefault
) (
  input logic      clk,
  input logic      rst,
  dccs_req_if.sink   req,
  dccs_rsp_if.source rsp,
  dccs_cfg_if.sink   cfg
);
  import dccs_pkg::*;

  dccs_cfg_t    cfg_regs;
  dccs_result_t step_result;

  // input register
  logic        req_full;
  logic [1:0]  req_command;
  logic [63:0] req_tag_word;

  // result register
  logic         rsp_full;
  dccs_result_t rsp_word;

  logic step;

  // step when an input word waits and the result slot is free or draining
  assign step      = req_full && (!rsp_full || rsp.ready);
  assign req.ready = !req_full || step;
  assign cfg.ready = 1'b1;

  dccs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg.valid && cfg.ready),
    .index (cfg.index),
    .data  (cfg.data),
    .regs  (cfg_regs)
  );

  dccs_seq #(
    .STACK_DEPTH (STACK_DEPTH),
    .SLICE_QUOTA (SLICE_QUOTA)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .command  (req_command),
    .tag_word (req_tag_word),
    .cfg      (cfg_regs),
    .result   (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (req.valid && req.ready) begin
      req_full <= 1'b1;
    end else if (step) begin
      req_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_command  <= req.command;
      req_tag_word <= req.tag_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_full <= 1'b0;
    end else if (step) begin
      rsp_full <= 1'b1;
    end else if (rsp.ready) begin
      rsp_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_word <= step_result;
    end
  end

  assign rsp.valid       = rsp_full;
  assign rsp.action      = rsp_word.action;
  assign rsp.bus_address = rsp_word.bus_address;
  assign rsp.status      = rsp_word.status;
  assign rsp.fetched_id  = rsp_word.fetched_id;

endmodule

// ===== design/dccs_cfg.sv =====
module dccs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               we,
  input  logic [dccs_pkg::CfgIndexWidth-1:0] index,
  input  logic [dccs_pkg::CfgDataWidth-1:0]  data,
  output dccs_pkg::dccs_cfg_t                regs
);
  import dccs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (we) begin
      unique case (index)
        REG_TRANSFER_MODE:     regs.transfer_mode     <= data[1:0];
        REG_START_MEM_ADDRESS: regs.start_mem_address <= data;
        REG_START_QWORD_COUNT: regs.start_qword_count <= data[15:0];
        REG_START_TAG_ADDRESS: regs.start_tag_address <= data;
        REG_TAG_IRQ_ENABLE:    regs.tag_irq_enable    <= data[0];
        REG_TRANSFER_RUN:      regs.transfer_run      <= data[7:0];
        REG_SKIP_RUN:          regs.skip_run          <= data[7:0];
        REG_SLICE_MODE:        regs.slice_mode        <= data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/dccs_seq.sv =====
module dccs_seq #(
  parameter int STACK_DEPTH = dccs_pkg::StackDepthDefault,
  parameter int SLICE_QUOTA = dccs_pkg::SliceQuotaDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [1:0]             command,
  input  logic [63:0]            tag_word,
  input  dccs_pkg::dccs_cfg_t    cfg,
  output dccs_pkg::dccs_result_t result
);
  import dccs_pkg::*;

  localparam int LevelW = $clog2(STACK_DEPTH + 1);
  localparam int IdxW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SliceW = (SLICE_QUOTA > 1) ? $clog2(SLICE_QUOTA) : 1;

  logic              running, running_next;
  logic [31:0]       work_address, work_address_next;
  logic [15:0]       remaining_count, remaining_count_next;
  logic [31:0]       tag_address, tag_address_next;
  logic              packet_irq, packet_irq_next;
  logic              exit_pending, exit_pending_next;
  logic [LevelW-1:0] stack_level, stack_level_next;
  logic [31:0]       return_stack [STACK_DEPTH];
  logic              skip_phase, skip_phase_next;
  logic [7:0]        phase_count, phase_count_next;
  logic [SliceW-1:0] slice_count, slice_count_next;

  logic              push;
  logic [31:0]       push_data;

  // slice quota bookkeeping for a moved qword
  logic [SliceW:0]   slice_inc;
  logic              slice_wrap;
  logic [SliceW-1:0] slice_after;
  logic              slice_hit;

  // tag fields
  logic [15:0] qwc;
  logic [2:0]  tag_id;
  logic [31:0] tag_after, tag_beyond;
  logic [20:0] packet_bytes;
  logic [7:0]  phase_inc, phase_limit;
  logic        stop;

  assign slice_inc   = {1'b0, slice_count} + (SliceW + 1)'(1);
  assign slice_wrap  = slice_inc >= (SliceW + 1)'(SLICE_QUOTA);
  assign slice_after = slice_wrap ? '0 : slice_inc[SliceW-1:0];
  assign slice_hit   = slice_wrap && cfg.slice_mode;

  assign qwc          = tag_word[15:0];
  assign tag_id       = tag_word[30:28];
  assign packet_bytes = {({1'b0, qwc} + 17'd1), 4'b0};
  assign tag_after    = adv(tag_address, QwordBytes);
  assign tag_beyond   = adv(tag_address, {10'b0, packet_bytes});
  assign phase_inc    = phase_count + 8'd1;
  assign phase_limit  = skip_phase ? cfg.skip_run : cfg.transfer_run;

  always_comb begin
    running_next         = running;
    work_address_next    = work_address;
    remaining_count_next = remaining_count;
    tag_address_next     = tag_address;
    packet_irq_next      = packet_irq;
    exit_pending_next    = exit_pending;
    stack_level_next     = stack_level;
    skip_phase_next      = skip_phase;
    phase_count_next     = phase_count;
    slice_count_next     = slice_count;
    push                 = 1'b0;
    push_data            = tag_beyond;
    stop                 = 1'b0;
    result               = '{action: ACT_NONE, bus_address: '0, status: ST_BUSY,
                             fetched_id: '0};

    unique case (command)
      CMD_START: begin
        work_address_next    = cfg.start_mem_address;
        remaining_count_next = cfg.start_qword_count;
        tag_address_next     = cfg.start_tag_address;
        packet_irq_next      = 1'b0;
        exit_pending_next    = 1'b0;
        stack_level_next     = '0;
        skip_phase_next      = 1'b0;
        phase_count_next     = '0;
        slice_count_next     = '0;
        running_next         = 1'b1;
      end
      CMD_RESUME: running_next = 1'b1;
      CMD_TICK: begin
        if (!running) begin
          result.status = ST_STOPPED;
        end else if (cfg.transfer_mode == MODE_CHAIN) begin
          if (remaining_count != '0) begin
            result.action        = ACT_MOVE;
            result.bus_address   = work_address;
            work_address_next    = adv(work_address, QwordBytes);
            remaining_count_next = remaining_count - 16'd1;
            slice_count_next     = slice_after;
            if (remaining_count_next == '0) begin
              stop = cfg.tag_irq_enable && packet_irq || exit_pending;
              if (exit_pending) begin
                exit_pending_next = 1'b0;
                stack_level_next  = '0;
              end
            end
            if (stop) begin
              running_next  = 1'b0;
              result.status = ST_FINISHED;
            end else if (slice_hit) begin
              running_next  = 1'b0;
              result.status = ST_PAUSE;
            end
          end else begin
            result.action        = ACT_FETCH;
            result.bus_address   = tag_address;
            result.fetched_id    = tag_id;
            packet_irq_next      = tag_word[31];
            remaining_count_next = qwc;
            work_address_next    = tag_after;
            unique case (tag_id)
              TAG_REFE: begin
                work_address_next = tag_word[63:32];
                exit_pending_next = 1'b1;
              end
              TAG_CNT:  tag_address_next = tag_beyond;
              TAG_NEXT: tag_address_next = tag_word[63:32];
              TAG_REF, TAG_REFS: begin
                work_address_next = tag_word[63:32];
                tag_address_next  = tag_after;
              end
              TAG_CALL: begin
                if (stack_level >= LevelW'(STACK_DEPTH)) begin
                  exit_pending_next = 1'b1;
                end else begin
                  push             = 1'b1;
                  stack_level_next = stack_level + LevelW'(1);
                end
                tag_address_next = tag_word[63:32];
              end
              TAG_RET: begin
                if (stack_level != '0 && stack_level <= LevelW'(STACK_DEPTH)) begin
                  stack_level_next = stack_level - LevelW'(1);
                  tag_address_next = return_stack[stack_level_next[IdxW-1:0]];
                end else begin
                  exit_pending_next = 1'b1;
                end
              end
              default: exit_pending_next = 1'b1;
            endcase
            if (qwc == '0) begin
              stop = cfg.tag_irq_enable && tag_word[31] || exit_pending_next;
              if (exit_pending_next) begin
                exit_pending_next = 1'b0;
                stack_level_next  = '0;
              end
              if (stop) begin
                running_next  = 1'b0;
                result.status = ST_FINISHED;
              end
            end
          end
        end else if (remaining_count == '0) begin
          running_next  = 1'b0;
          result.status = ST_ZERO_ERR;
        end else begin
          // normal and interleave share the address walk
          result.bus_address = work_address;
          work_address_next  = adv(work_address, QwordBytes);
          if (cfg.transfer_mode == MODE_INTERLEAVE && skip_phase) begin
            result.action = ACT_SKIP;
          end else begin
            result.action        = ACT_MOVE;
            remaining_count_next = remaining_count - 16'd1;
            slice_count_next     = slice_after;
          end
          if (cfg.transfer_mode == MODE_INTERLEAVE) begin
            if (phase_inc >= phase_limit) begin
              skip_phase_next  = !skip_phase;
              phase_count_next = '0;
            end else begin
              phase_count_next = phase_inc;
            end
          end
          if (remaining_count_next == '0) begin
            running_next  = 1'b0;
            result.status = ST_FINISHED;
          end else if (result.action == ACT_MOVE && slice_hit) begin
            running_next  = 1'b0;
            result.status = ST_PAUSE;
          end
        end
      end
      default: result.status = running ? ST_BUSY : ST_STOPPED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      work_address    <= '0;
      remaining_count <= '0;
      tag_address     <= '0;
      packet_irq      <= 1'b0;
      exit_pending    <= 1'b0;
      stack_level     <= '0;
      skip_phase      <= 1'b0;
      phase_count     <= '0;
      slice_count     <= '0;
    end else if (step) begin
      running         <= running_next;
      work_address    <= work_address_next;
      remaining_count <= remaining_count_next;
      tag_address     <= tag_address_next;
      packet_irq      <= packet_irq_next;
      exit_pending    <= exit_pending_next;
      stack_level     <= stack_level_next;
      skip_phase      <= skip_phase_next;
      phase_count     <= phase_count_next;
      slice_count     <= slice_count_next;
    end
  end

  // return stack, no reset: only entries below stack_level are read
  always_ff @(posedge clk) begin
    if (step && push) begin
      return_stack[stack_level[IdxW-1:0]] <= push_data;
    end
  end

endmodule
